// ===== design/sdes_byte_cipher_macros.svh =====
// Assertion macros used by the port-level checker of the byte cipher.
`ifndef SDES_BYTE_CIPHER_MACROS_SVH
`define SDES_BYTE_CIPHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDES_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SDES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sdes_pkg.sv =====
`timescale 1ns / 1ps

package sdes_pkg;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned KEY_W    = 10;
    localparam int unsigned SUBKEY_W = 8;
    localparam int unsigned HALF_W   = 5;
    localparam int unsigned NIB_W    = 4;

    typedef logic [DATA_W-1:0]   t_byte;
    typedef logic [KEY_W-1:0]    t_key;
    typedef logic [SUBKEY_W-1:0] t_subkey;
    typedef logic [HALF_W-1:0]   t_half;
    typedef logic [NIB_W-1:0]    t_nib;

    typedef enum logic {
        ACT_ENCRYPT = 1'b0,
        ACT_DECRYPT = 1'b1
    } t_action;

    typedef struct packed {
        t_subkey k1;
        t_subkey k2;
    } t_subkeys;

    // Permutation tables, entries are source positions counted from the MSB.
    localparam int P10 [10] = '{2, 4, 1, 6, 3, 9, 0, 8, 7, 5};
    localparam int P8  [8]  = '{5, 2, 6, 3, 7, 4, 9, 8};
    localparam int IP  [8]  = '{1, 5, 2, 0, 3, 7, 4, 6};
    localparam int IPI [8]  = '{3, 0, 2, 4, 6, 1, 7, 5};
    localparam int EP  [8]  = '{3, 0, 1, 2, 1, 2, 3, 0};
    localparam int P4  [4]  = '{1, 3, 2, 0};

    localparam logic [1:0] SBOX1 [4][4] = '{
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd3, 2'd2, 2'd1, 2'd0},
        '{2'd0, 2'd2, 2'd1, 2'd3},
        '{2'd3, 2'd1, 2'd0, 2'd2}
    };
    localparam logic [1:0] SBOX2 [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd2, 2'd3, 2'd1, 2'd0},
        '{2'd3, 2'd0, 2'd1, 2'd2},
        '{2'd2, 2'd1, 2'd0, 2'd3}
    };

    function automatic t_key f_p10(input t_key v);
        t_key r;
        for (int i = 0; i < 10; i++) begin
            r[9-i] = v[9-P10[i]];
        end
        return r;
    endfunction

    function automatic t_subkey f_p8(input t_key v);
        t_subkey r;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = v[9-P8[i]];
        end
        return r;
    endfunction

    function automatic t_byte f_ip(input t_byte v);
        t_byte r;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = v[7-IP[i]];
        end
        return r;
    endfunction

    function automatic t_byte f_ipi(input t_byte v);
        t_byte r;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = v[7-IPI[i]];
        end
        return r;
    endfunction

    function automatic t_byte f_ep(input t_nib v);
        t_byte r;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = v[3-EP[i]];
        end
        return r;
    endfunction

    function automatic t_nib f_p4(input t_nib v);
        t_nib r;
        for (int i = 0; i < 4; i++) begin
            r[3-i] = v[3-P4[i]];
        end
        return r;
    endfunction

    function automatic t_half f_rot5(input t_half h);
        return {h[3:0], h[4]};
    endfunction

    // Round function: expand, mix in the subkey, two S-boxes, then P4.
    function automatic t_nib f_round(input t_nib nib, input t_subkey sk);
        t_byte t;
        t_nib  s;
        t = f_ep(nib) ^ sk;
        s = {SBOX1[{t[7], t[4]}][{t[6], t[5]}], SBOX2[{t[3], t[0]}][{t[2], t[1]}]};
        return f_p4(s);
    endfunction

    function automatic t_byte f_feistel(input t_byte v, input t_subkey sk);
        return {v[7:4] ^ f_round(v[3:0], sk), v[3:0]};
    endfunction

    function automatic t_byte f_swap(input t_byte v);
        return {v[3:0], v[7:4]};
    endfunction

endpackage

// ===== design/sdes_if.sv =====
`timescale 1ns / 1ps

// Input byte channel.
interface sdes_in_if;
    import sdes_pkg::*;
    logic    valid;
    logic    ready;
    t_action action;
    t_byte   data_in;

    modport source (output valid, output action, output data_in, input ready);
    modport sink   (input valid, input action, input data_in, output ready);
endinterface

// Result byte channel.
interface sdes_out_if;
    import sdes_pkg::*;
    logic  valid;
    logic  ready;
    t_byte data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

// Key write channel.
interface sdes_cfg_if;
    import sdes_pkg::*;
    logic valid;
    logic ready;
    t_key secret_key;

    modport source (output valid, output secret_key, input ready);
    modport sink   (input valid, input secret_key, output ready);
endinterface

// ===== design/sdes_key_sched.sv =====
`timescale 1ns / 1ps

// Holds the key register and derives both round subkeys from it.
module sdes_key_sched
    import sdes_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdes_cfg_if.sink   i_cfg,
    output t_subkeys   o_subkeys
);

    t_key  r_secret_key;
    t_key  p10_key;
    t_half left1;
    t_half right1;
    t_half left2;
    t_half right2;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_secret_key <= '0;
        end else if (i_cfg.valid) begin
            r_secret_key <= i_cfg.secret_key;
        end
    end

    always_comb begin
        p10_key      = f_p10(r_secret_key);
        left1        = f_rot5(p10_key[9:5]);
        right1       = f_rot5(p10_key[4:0]);
        left2        = f_rot5(left1);
        right2       = f_rot5(right1);
        o_subkeys.k1 = f_p8({left1, right1});
        o_subkeys.k2 = f_p8({left2, right2});
    end

endmodule

// ===== design/sdes_core.sv =====
`timescale 1ns / 1ps

// Input register, both cipher rounds in one combinational pass, result register.
module sdes_core
    import sdes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_subkeys    i_subkeys,
    sdes_in_if.sink     i_in,
    sdes_out_if.source  o_out
);

    logic    r_s1_valid;
    t_action r_s1_action;
    t_byte   r_s1_data;
    logic    r_out_valid;
    t_byte   r_out_data;

    logic    n_s1_valid;
    logic    n_out_valid;
    logic    s1_ready;
    logic    s2_ready;
    t_subkey first_key;
    t_subkey second_key;
    t_byte   result;

    assign s2_ready    = !r_out_valid || o_out.ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign i_in.ready  = s1_ready;
    assign n_s1_valid  = s1_ready ? i_in.valid : r_s1_valid;
    assign n_out_valid = s2_ready ? r_s1_valid : r_out_valid;

    always_comb begin
        t_byte v;
        if (r_s1_action == ACT_DECRYPT) begin
            first_key  = i_subkeys.k2;
            second_key = i_subkeys.k1;
        end else begin
            first_key  = i_subkeys.k1;
            second_key = i_subkeys.k2;
        end
        v      = f_ip(r_s1_data);
        v      = f_feistel(v, first_key);
        v      = f_swap(v);
        v      = f_feistel(v, second_key);
        result = f_ipi(v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in.valid) begin
            r_s1_action <= i_in.action;
            r_s1_data   <= i_in.data_in;
        end
        if (s2_ready && r_s1_valid) begin
            r_out_data <= result;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.data_out = r_out_data;

endmodule

// ===== design/sdes_byte_cipher.sv =====
`timescale 1ns / 1ps

// Simplified two-round DES on single bytes with a ten-bit key. Each input
// transaction carries one byte and an action bit (encrypt or decrypt) and
// produces exactly one output transaction with the resulting byte, in order.
// The block takes one byte every clock cycle as long as results are taken;
// each byte passes through the input register and then the result register,
// between which both rounds, the key schedule and the permutations are done
// in a single combinational pass. The key is written through the
// configuration channel, which is always ready; it resets to zero and must
// only be changed while no byte is in flight. Bit 0 of the key and data in
// the textbook numbering is the most significant bit of each vector here.
module sdes_byte_cipher
    import sdes_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdes_cfg_if.sink   i_cfg,
    sdes_in_if.sink    i_in,
    sdes_out_if.source o_out
);

    t_subkeys subkeys;

    // Key register and subkey derivation.
    sdes_key_sched u_key_sched (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_subkeys (subkeys)
    );

    // Two-stage data path; the result register decouples the output side.
    sdes_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_subkeys (subkeys),
        .i_in      (i_in),
        .o_out     (o_out)
    );

endmodule

// ===== design/sdes_checker.sv =====
`timescale 1ns / 1ps
`include "sdes_byte_cipher_macros.svh"

// Port-level checks of the byte cipher.
module sdes_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_valid,
    input logic       i_cfg_ready,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_data
);

    `SDES_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "stalled result changed")
    `SDES_ASSERT_NOW(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, i_cfg_ready, "key write not taken")
    `SDES_ASSERT_NOW(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !i_out_valid, "result valid after reset")
    `SDES_ASSERT_NEXT(a_no_phantom, i_clk, i_rst_n, !i_out_valid && !$past(i_in_valid && i_in_ready), !i_out_valid, "result without input")

endmodule

bind sdes_byte_cipher sdes_checker u_sdes_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data_out)
);

// ===== tb/sv/sdes_result_checker.sv =====
`timescale 1ns / 1ps

module sdes_result_checker
    import sdes_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sdes_cfg_if  i_cfg,
    sdes_in_if   i_in,
    sdes_out_if  i_out,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_checked
);

    // Bit maps, one hex digit per output bit, first digit for the MSB.
    // Each digit is the source position counted from the MSB.
    localparam logic [39:0] MAP_P10 = 40'h2416390875;
    localparam logic [39:0] MAP_P8  = 40'h5263749800;
    localparam logic [39:0] MAP_IP  = 40'h1520374600;
    localparam logic [39:0] MAP_IPI = 40'h3024617500;
    localparam logic [39:0] MAP_EP  = 40'h3012123000;
    localparam logic [39:0] MAP_P4  = 40'h1320000000;

    // Substitution boxes, sixteen entries in row-major order, one digit each.
    localparam logic [63:0] SBOX_A = 64'h1032_3210_0213_3102;
    localparam logic [63:0] SBOX_B = 64'h0123_2310_3012_2103;

    t_key  key_copy;
    t_byte expected_bytes[$];
    t_byte want;
    int    mismatches = 0;
    int    pending    = 0;
    int    checked    = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = pending;
    assign o_checked    = checked;

    // Generic bit reorder; the result is right-aligned in ten bits.
    function automatic logic [9:0] pick_bits(input logic [9:0] src, input int in_w,
                                             input int out_w, input logic [39:0] map);
        logic [9:0] r;
        int         src_pos;
        r = '0;
        for (int i = 0; i < out_w; i++) begin
            src_pos = int'(map[39-4*i -: 4]);
            r = {r[8:0], src[in_w-1-src_pos]};
        end
        return r;
    endfunction

    function automatic logic [1:0] sbox_lookup(input logic [63:0] tbl, input logic [1:0] row,
                                               input logic [1:0] col);
        int         idx;
        logic [3:0] entry;
        idx   = int'({row, col});
        entry = tbl[63-4*idx -: 4];
        return entry[1:0];
    endfunction

    function automatic t_nib round_mix(input t_nib nib, input t_subkey sk);
        logic [9:0] w;
        logic [7:0] t;
        logic [3:0] s;
        w = pick_bits({6'b0, nib}, 4, 8, MAP_EP);
        t = w[7:0] ^ sk;
        s = {sbox_lookup(SBOX_A, {t[7], t[4]}, {t[6], t[5]}),
             sbox_lookup(SBOX_B, {t[3], t[0]}, {t[2], t[1]})};
        w = pick_bits({6'b0, s}, 4, 4, MAP_P4);
        return w[3:0];
    endfunction

    // Expected output byte for one transaction under the given key.
    function automatic t_byte sdes_transform(input t_action act, input t_byte data,
                                             input t_key key);
        logic [9:0] w;
        logic [4:0] lh;
        logic [4:0] rh;
        t_subkey    k1;
        t_subkey    k2;
        t_subkey    ka;
        t_subkey    kb;
        t_byte      v;
        w  = pick_bits(key, 10, 10, MAP_P10);
        lh = {w[8:5], w[9]};
        rh = {w[3:0], w[4]};
        w  = pick_bits({lh, rh}, 10, 8, MAP_P8);
        k1 = w[7:0];
        lh = {lh[3:0], lh[4]};
        rh = {rh[3:0], rh[4]};
        w  = pick_bits({lh, rh}, 10, 8, MAP_P8);
        k2 = w[7:0];
        ka = (act == ACT_DECRYPT) ? k2 : k1;
        kb = (act == ACT_DECRYPT) ? k1 : k2;
        w  = pick_bits({2'b0, data}, 8, 8, MAP_IP);
        v  = w[7:0];
        v  = {v[7:4] ^ round_mix(v[3:0], ka), v[3:0]};
        v  = {v[3:0], v[7:4]};
        v  = {v[7:4] ^ round_mix(v[3:0], kb), v[3:0]};
        w  = pick_bits({2'b0, v}, 8, 8, MAP_IPI);
        return w[7:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_copy = '0;
            expected_bytes.delete();
        end else begin
            // Results are compared before this edge's input is queued, so a
            // stray output can never pair up with a byte accepted in the same cycle.
            if (i_out.valid && i_out.ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %02h",
                             $time, i_out.data_out);
                    mismatches++;
                end else begin
                    want = expected_bytes.pop_front();
                    checked++;
                    if (i_out.data_out !== want) begin
                        $display("%0t: data_out mismatch, expected %02h, actual %02h",
                                 $time, want, i_out.data_out);
                        mismatches++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                expected_bytes.push_back(sdes_transform(i_in.action, i_in.data_in, key_copy));
            end
            if (i_cfg.valid && i_cfg.ready) begin
                key_copy = i_cfg.secret_key;
            end
        end
        pending = expected_bytes.size();
    end

endmodule

// ===== tb/sv/tb_sdes_byte_cipher.sv =====
`timescale 1ns / 1ps

module tb_sdes_byte_cipher;
    import sdes_pkg::*;

    // Directed corner bytes: all zeros, all ones, single MSB and LSB, and
    // alternating bit and nibble patterns.
    localparam logic [63:0] CORNER_BYTES = 64'h00FF_0180_AA55_0FF0;
    localparam int          BLOCKS       = 18;
    localparam int          BLOCK_ITEMS  = 75;
    localparam int          HOLD_CYCLES  = 60;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sdes_cfg_if cfg_ch ();
    sdes_in_if  in_ch ();
    sdes_out_if out_ch ();

    int fail_count;
    int pending_count;
    int checked_count;

    // Idle rates in percent of cycles; the stimulus changes them per phase.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // The stimulus bumps this counter to ask the receiver for a long stall.
    int hold_requests = 0;

    int bytes_sent    = 0;
    int decrypts_sent = 0;
    int keys_written  = 0;

    always #5 clk = ~clk;

    sdes_byte_cipher dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sdes_result_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg        (cfg_ch),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_mismatches (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    // Offer one byte. Idle cycles are inserted before the offer, and the
    // transaction completes at the first rising edge that sees ready high.
    // Valid is left high afterwards so back-to-back bytes need no gap.
    task automatic send_byte(input t_action act, input t_byte data);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.action  = act;
        in_ch.data_in = data;
        do @(posedge clk); while (!in_ch.ready);
        bytes_sent++;
        if (act == ACT_DECRYPT) begin
            decrypts_sent++;
        end
    endtask

    // Stop offering and wait until every byte in flight has come out. The
    // short pause afterwards covers the block's latency.
    task automatic drain;
        @(negedge clk);
        in_ch.valid = 1'b0;
        wait (pending_count == 0);
        repeat (3) @(posedge clk);
    endtask

    // Key writes are only issued while the block is drained.
    task automatic write_key(input t_key key);
        @(negedge clk);
        cfg_ch.valid      = 1'b1;
        cfg_ch.secret_key = key;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        keys_written++;
    endtask

    // Receiver: decides ready once per cycle at the falling edge. A long
    // stall request is counted down here, independent of the stimulus, so
    // the sender keeps pushing while the block backs up.
    initial begin
        int hold_left;
        int served;
        hold_left    = 0;
        served       = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (served != hold_requests) begin
                served    = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else begin
                out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Stimulus: reset, a directed pass over corner bytes with the reset key
    // and with the all-ones key, then random blocks under changing keys and
    // idle patterns.
    initial begin
        t_key key;
        cfg_ch.valid      = 1'b0;
        cfg_ch.secret_key = '0;
        in_ch.valid       = 1'b0;
        in_ch.action      = ACT_ENCRYPT;
        in_ch.data_in     = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The reset key of zero is exercised before any write.
        for (int i = 0; i < 8; i++) begin
            send_byte(ACT_ENCRYPT, CORNER_BYTES[63-8*i -: 8]);
            send_byte(ACT_DECRYPT, CORNER_BYTES[63-8*i -: 8]);
        end
        drain();
        write_key(10'h3FF);
        for (int i = 0; i < 8; i++) begin
            send_byte((i % 2 == 0) ? ACT_ENCRYPT : ACT_DECRYPT, CORNER_BYTES[63-8*i -: 8]);
        end

        // Random blocks. The first third has a slow receiver, the second a
        // slow sender, and the last runs with neither side idling. Each block
        // starts from a drained pipeline with a new key.
        for (int blk = 0; blk < BLOCKS; blk++) begin
            case (blk / 6)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct = 88;
                end
                1: begin
                    send_idle_pct = 88;
                    recv_idle_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (blk)
                0:       key = 10'h000;
                1:       key = 10'h3FF;
                2:       key = 10'h2AA;
                3:       key = 10'h155;
                12:      key = 10'h3FF;
                default: key = t_key'($urandom_range(0, 1023));
            endcase
            drain();
            write_key(key);
            for (int i = 0; i < BLOCK_ITEMS; i++) begin
                // One long output stall while the sender keeps offering at
                // full rate, so the block fills up and drops its input ready.
                if (blk == 12 && i == 10) begin
                    hold_requests++;
                end
                send_byte(t_action'($urandom_range(0, 1)), t_byte'($urandom_range(0, 255)));
            end
        end

        drain();
        repeat (5) @(posedge clk);

        $display("Sent %0d bytes (%0d decrypts) under %0d key writes plus the reset key.",
                 bytes_sent, decrypts_sent, keys_written);
        $display("Checked %0d results across slow-receiver, slow-sender and full-rate phases.",
                 checked_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASS sdes_byte_cipher");
        end else begin
            $display("FAIL sdes_byte_cipher");
        end
        $finish;
    end

    // Watchdog: the slowest legal run needs well under a tenth of this.
    initial begin
        #(2_000_000);
        $display("FAIL sdes_byte_cipher");
        $finish;
    end

endmodule
